// ----- hdl/twcg_pkg.sv -----
// shared types and constants for the textured wall column generator
`default_nettype none
package twcg_pkg;
  localparam int SCREEN_ROWS = 512;
  localparam int NUM_TEXTURES = 8;
  localparam int TEX_W = 64;
  localparam int TEX_H = 64;
  localparam int STORE_SIZE = NUM_TEXTURES * TEX_W * TEX_H;
  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int CNT_W = ROW_W + 1;
  localparam int TX_W = $clog2(TEX_W);
  localparam int TY_W = $clog2(TEX_H);
  localparam int SEL_W = (NUM_TEXTURES > 1) ? $clog2(NUM_TEXTURES) : 1;
  localparam int ADDR_W = $clog2(STORE_SIZE);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam logic [23:0] HALF_MASK = 24'h7F7F7F;
  localparam logic [23:0] RGB_MASK = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SETUP = 2'd1,
    OP_STEP = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_CEILING = 2'd0,
    REG_FLOOR = 2'd1,
    REG_DOOR = 2'd2
  } reg_index_t;

  // command handed from front to back
  typedef struct packed {
    logic        is_load;
    logic [14:0] addr;
    logic [23:0] data;
  } cmd_t;

  // column state loaded by the front after setup
  typedef struct packed {
    logic             load;
    logic [TX_W-1:0]  tex_x;
    logic             side;
    logic [SEL_W-1:0] texture;
    logic [8:0]       top;
    logic [8:0]       bottom;
    logic [31:0]      position;
    logic [31:0]      increment;
  } column_t;
endpackage
`default_nettype wire

// ----- hdl/textured_wall_column_generator_unit.sv -----
// top level of the textured wall column generator
`default_nettype none
// Texel loads and pixel steps are taken one a cycle while full is low, and
// pass through a four-entry queue to the back end, which emits one row a
// cycle while pop keeps the output free, through a registered texture store
// read and an output register. A column setup holds the input through a
// multiply, a bit-serial divide for the texture step, a multiply for the
// start position, then a drain of the queued work before the new column
// takes effect. The texture store needs no clearing after reset.
module textured_wall_column_generator_unit
  import twcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode,
  input  wire logic [14:0] texel_addr,
  input  wire logic [23:0] texel_color,
  input  wire logic [2:0]  tex_sel,
  input  wire logic        side,
  input  wire logic [8:0]  slice_top,
  input  wire logic [8:0]  slice_bottom,
  input  wire logic [15:0] slice_height,
  input  wire logic [25:0] wall_dist,
  input  wire logic signed [17:0] dir_x,
  input  wire logic signed [17:0] dir_y,
  input  wire logic [25:0] player_along,
  output logic             empty,
  input  wire logic        pop,
  output logic [8:0]       row,
  output logic [23:0]      color,
  output logic             write_enable,
  output logic             last_row
);
  logic [23:0] ceil_rgb, floor_rgb;
  logic [2:0]  door_texture;
  logic q_valid, q_take, back_idle;
  cmd_t q_cmd;
  column_t column;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceil_rgb <= '0;
      floor_rgb <= '0;
      door_texture <= 3'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CEILING: ceil_rgb <= cfg_data;
        REG_FLOOR: floor_rgb <= cfg_data;
        REG_DOOR: door_texture <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  twcg_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .texel_addr(texel_addr), .texel_color(texel_color), .tex_sel(tex_sel),
    .side(side), .slice_top(slice_top), .slice_bottom(slice_bottom),
    .slice_height(slice_height), .wall_dist(wall_dist), .dir_x(dir_x),
    .dir_y(dir_y), .player_along(player_along), .q_valid(q_valid),
    .q_cmd(q_cmd), .q_take(q_take), .back_idle(back_idle), .column(column)
  );

  twcg_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
    .back_idle(back_idle), .column(column), .ceil_rgb(ceil_rgb),
    .floor_rgb(floor_rgb), .door_texture(door_texture), .empty(empty),
    .pop(pop), .row(row), .color(color), .write_enable(write_enable),
    .last_row(last_row)
  );
endmodule
`default_nettype wire

// ----- hdl/twcg_divider.sv -----
// restoring divider for the texture step, one quotient bit a cycle
`default_nettype none
module twcg_divider
  import twcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  localparam logic [31:0] DIVIDEND = 32'(TEX_H) << 16;
  logic [31:0] dividend;
  logic [16:0] remainder;
  logic [15:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic [16:0] trial;

  always_comb begin
    trial = {remainder[15:0], dividend[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dividend <= DIVIDEND;
        remainder <= '0;
        dvs <= divisor;
        count <= 6'd32;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          remainder <= trial - {1'b0, dvs};
          quotient <= {quotient[30:0], 1'b1};
        end else begin
          remainder <= trial;
          quotient <= {quotient[30:0], 1'b0};
        end
        dividend <= {dividend[30:0], 1'b0};
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/twcg_front.sv -----
// front end: accepts items, runs column setup, queues texel loads and steps
`default_nettype none
module twcg_front
  import twcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode,
  input  wire logic [14:0] texel_addr,
  input  wire logic [23:0] texel_color,
  input  wire logic [2:0]  tex_sel,
  input  wire logic        side,
  input  wire logic [8:0]  slice_top,
  input  wire logic [8:0]  slice_bottom,
  input  wire logic [15:0] slice_height,
  input  wire logic [25:0] wall_dist,
  input  wire logic signed [17:0] dir_x,
  input  wire logic signed [17:0] dir_y,
  input  wire logic [25:0] player_along,
  output logic             q_valid,
  output cmd_t             q_cmd,
  input  wire logic        q_take,
  input  wire logic        back_idle,
  output column_t          column
);
  typedef enum logic [4:0] {
    S_RUN   = 5'b00001,
    S_MUL   = 5'b00010,
    S_DIV   = 5'b00100,
    S_POS   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state;
  cmd_t q_mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;
  logic q_full, accept, enq;

  logic [15:0] lh;
  logic [8:0]  ds, de;
  logic        sd;
  logic [SEL_W-1:0] sel;
  logic signed [17:0] dx_r, dy_r;
  logic [25:0] dist_r, along_r;
  logic signed [44:0] prod;
  logic [TX_W-1:0] tx;
  logic div_start, div_done;
  logic [31:0] quot, incr;
  logic signed [31:0] off;
  logic [31:0] pos;
  logic [15:0] frac;
  logic [15:0] lh_in;

  twcg_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(lh_in),
    .done(div_done), .quotient(quot)
  );

  assign q_full = (count == (QPTR_W+1)'(QDEPTH));
  assign full = (state != S_RUN) || q_full;
  assign accept = push && !full;
  assign enq = accept && (opcode == OP_LOAD || opcode == OP_STEP);
  assign q_valid = (count != '0);
  assign q_cmd = q_mem[rptr];
  assign lh_in = (slice_height == 16'd0) ? 16'd1 : slice_height;
  assign div_start = accept && opcode == OP_SETUP;

  always_comb begin
    frac = 16'(({along_r, 16'd0} + 42'(unsigned'(prod))) >> 16);
    tx = TX_W'((32'(frac) * 32'(TEX_W)) >> 16);
    if ((!sd && dx_r > 0) || (sd && dy_r < 0)) begin
      tx = TX_W'(TEX_W - 1) - tx;
    end
    off = 32'(signed'({1'b0, ds})) - 32'(SCREEN_ROWS / 2) + 32'({1'b0, lh[15:1]});
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wptr] <= '{is_load: (opcode == OP_LOAD), addr: texel_addr, data: texel_color};
    end
    if (accept && opcode == OP_SETUP) begin
      lh <= lh_in;
      ds <= slice_top;
      de <= slice_bottom;
      sd <= side;
      sel <= SEL_W'(tex_sel % NUM_TEXTURES);
      dx_r <= dir_x;
      dy_r <= dir_y;
      dist_r <= wall_dist;
      along_r <= player_along;
    end
    if (state == S_MUL) begin
      prod <= signed'({1'b0, dist_r}) * (sd ? dx_r : dy_r);
    end
    if (div_done) begin
      incr <= quot;
    end
    if (state == S_POS) begin
      pos <= unsigned'(off) * incr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      wptr <= '0;
      rptr <= '0;
      count <= '0;
      column.load <= 1'b0;
    end else begin
      column.load <= (state == S_DRAIN) && !q_valid && back_idle;
      if (enq) wptr <= wptr + 1'b1;
      if (q_take) rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(enq) - (QPTR_W+1)'(q_take);
      unique case (state)
        S_RUN: if (div_start) state <= S_MUL;
        S_MUL: state <= S_DIV;
        S_DIV: if (div_done) state <= S_POS;
        S_POS: state <= S_DRAIN;
        S_DRAIN: begin
          if (!q_valid && back_idle) begin
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
      if (state == S_DRAIN) begin
        column.tex_x <= tx;
        column.side <= sd;
        column.texture <= sel;
        column.top <= ds;
        column.bottom <= de;
        column.position <= pos;
        column.increment <= incr;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/twcg_back.sv -----
// back end: texture store, row walk and result register
`default_nettype none
module twcg_back
  import twcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output logic             q_take,
  output logic             back_idle,
  input  wire column_t     column,
  input  wire logic [23:0] ceil_rgb,
  input  wire logic [23:0] floor_rgb,
  input  wire logic [2:0]  door_texture,
  output logic             empty,
  input  wire logic        pop,
  output logic [8:0]       row,
  output logic [23:0]      color,
  output logic             write_enable,
  output logic             last_row
);
  logic [23:0] store [STORE_SIZE];
  logic [CNT_W-1:0] rc;
  logic [31:0] position, increment;
  logic [TX_W-1:0] tex_x;
  logic cside;
  logic [SEL_W-1:0] ctex;
  logic [8:0] top, bottom;

  // stage 1: memory read in flight
  logic        s1_valid, s1_wall, s1_last;
  logic [8:0]  s1_row;
  logic [23:0] s1_flat, rd;
  // output register
  logic        o_valid;
  logic        s1_free, o_free;
  logic [ADDR_W-1:0] addr;
  logic [23:0] tc;
  logic        wall;

  assign o_free = !o_valid || pop;
  assign s1_free = !s1_valid || o_free;
  assign q_take = q_valid && (q_cmd.is_load || rc >= CNT_W'(SCREEN_ROWS) || s1_free);
  assign back_idle = !s1_valid;
  assign empty = !o_valid;
  assign wall = (rc >= CNT_W'(top)) && (rc <= CNT_W'(bottom));
  assign addr = ADDR_W'({ctex, position[16 +: TY_W], tex_x});

  always_comb begin
    tc = cside ? ((rd >> 1) & HALF_MASK) : rd;
  end

  always_ff @(posedge clk) begin
    if (q_take && q_cmd.is_load && 32'(q_cmd.addr) < 32'(STORE_SIZE)) begin
      store[ADDR_W'(q_cmd.addr)] <= q_cmd.data;
    end
    if (q_take && !q_cmd.is_load && rc < CNT_W'(SCREEN_ROWS)) begin
      rd <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && !q_cmd.is_load && rc < CNT_W'(SCREEN_ROWS)) begin
      s1_row <= ROW_W'(rc);
      s1_wall <= (rc < CNT_W'(top)) ? 1'b0 : wall;
      s1_flat <= (rc < CNT_W'(top)) ? ceil_rgb : floor_rgb;
      s1_last <= (rc == CNT_W'(SCREEN_ROWS - 1));
    end
    if (s1_valid && o_free) begin
      row <= s1_row;
      last_row <= s1_last;
      color <= s1_wall ? tc : s1_flat;
      write_enable <= !(s1_wall && SEL_W'(door_texture) == ctex && 3'(ctex) == door_texture
                        && tc == 24'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc <= '0;
      position <= '0;
      increment <= '0;
      tex_x <= '0;
      cside <= 1'b0;
      ctex <= '0;
      top <= '0;
      bottom <= '0;
      s1_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (o_free) o_valid <= s1_valid;
      if (s1_free) s1_valid <= 1'b0;
      if (column.load) begin
        rc <= '0;
        position <= column.position;
        increment <= column.increment;
        tex_x <= column.tex_x;
        cside <= column.side;
        ctex <= column.texture;
        top <= column.top;
        bottom <= column.bottom;
      end else if (q_take && !q_cmd.is_load && rc < CNT_W'(SCREEN_ROWS)) begin
        s1_valid <= 1'b1;
        rc <= rc + 1'b1;
        if (rc >= CNT_W'(top) && wall) position <= position + increment;
      end
    end
  end
endmodule
`default_nettype wire
